// ===== hw/rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the setpoint frame decoder
// Holds the frame layout, status codes, the record passed from the front
// part to the back part, and the byte-wide CRC-16-CCITT update.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int FRAME_LEN     = 24;
  localparam int PAYLOAD_DEPTH = 21;   // frame bytes 2..22
  localparam int FIELD_BYTES   = 20;   // frame bytes 2..21 carry the fields
  localparam int FIELD_W       = FIELD_BYTES * 8;

  localparam logic [4:0] IDX_FIRST   = 5'd0;
  localparam logic [4:0] IDX_VERSION = 5'd1;
  localparam logic [4:0] IDX_PAY_LO  = 5'd2;
  localparam logic [4:0] IDX_CRC_END = 5'd21;
  localparam logic [4:0] IDX_PAY_HI  = 5'd22;
  localparam logic [4:0] IDX_LAST    = 5'd23;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC   = 2'd1;
  localparam logic [1:0] ST_BAD_VERSION = 2'd2;
  localparam logic [1:0] ST_BAD_CRC     = 2'd3;

  localparam logic [7:0] REG_FRAME_MAGIC      = 8'd0;
  localparam logic [7:0] REG_PROTOCOL_VERSION = 8'd1;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] fields;   // frame bytes 2..21, byte 2 in the lowest bits
  } frame_rec_t;

  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } rec_port_t;

  // MSB-first CRC-16-CCITT update over one byte.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/sfd_front.sv =====
// ----------------------------------------------------------------------------
// sfd_front: byte intake and frame classification
// Counts frame bytes, runs the CRC, checks the header against the
// configuration registers and captures the payload. On the last byte of a
// frame it pushes one record into the queue.
// ----------------------------------------------------------------------------
module sfd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] rx_byte
  input  logic                in_tuser,   // [0] frame_start
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                queue_full,
  output sfd_pkg::rec_port_t  push
);

  logic [7:0]  magic_r, magic_nxt;
  logic [7:0]  version_r, version_nxt;
  logic [4:0]  byte_index_r, byte_index_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [1:0]  fault_r, fault_nxt;
  logic [7:0]  payload_r [sfd_pkg::PAYLOAD_DEPTH];

  logic        accept;
  logic [4:0]  idx;
  logic [15:0] rx_crc;
  logic [sfd_pkg::FIELD_W-1:0] fields;

  assign in_tready = !queue_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign idx       = in_tuser ? sfd_pkg::IDX_FIRST : byte_index_r;

  always_comb begin
    magic_nxt   = magic_r;
    version_nxt = version_r;
    if (cfg_valid) begin
      case (cfg_index)
        sfd_pkg::REG_FRAME_MAGIC:      magic_nxt   = cfg_data;
        sfd_pkg::REG_PROTOCOL_VERSION: version_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    byte_index_nxt = byte_index_r;
    crc_nxt        = crc_r;
    fault_nxt      = fault_r;
    if (accept) begin
      if (idx == sfd_pkg::IDX_FIRST) begin
        crc_nxt   = sfd_pkg::crc_byte(sfd_pkg::CRC_INIT, in_tdata);
        fault_nxt = (in_tdata != magic_r) ? sfd_pkg::ST_BAD_MAGIC : sfd_pkg::ST_OK;
      end else if (idx <= sfd_pkg::IDX_CRC_END) begin
        crc_nxt = sfd_pkg::crc_byte(crc_r, in_tdata);
        if (idx == sfd_pkg::IDX_VERSION && fault_r == sfd_pkg::ST_OK &&
            in_tdata != version_r) begin
          fault_nxt = sfd_pkg::ST_BAD_VERSION;
        end
      end
      byte_index_nxt = (idx == sfd_pkg::IDX_LAST) ? sfd_pkg::IDX_FIRST : idx + 5'd1;
    end
  end

  // The stored CRC is little endian: byte 22 low, byte 23 high.
  assign rx_crc = {in_tdata, payload_r[sfd_pkg::PAYLOAD_DEPTH-1]};

  always_comb begin
    for (int i = 0; i < sfd_pkg::FIELD_BYTES; i++) begin
      fields[i*8 +: 8] = payload_r[i];
    end
  end

  always_comb begin
    push.valid      = accept && (idx == sfd_pkg::IDX_LAST);
    push.rec.fields = fields;
    if (fault_r != sfd_pkg::ST_OK) begin
      push.rec.status = fault_r;
    end else if (rx_crc != crc_r) begin
      push.rec.status = sfd_pkg::ST_BAD_CRC;
    end else begin
      push.rec.status = sfd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r      <= 8'h00;
      version_r    <= 8'h00;
      byte_index_r <= sfd_pkg::IDX_FIRST;
      crc_r        <= sfd_pkg::CRC_INIT;
      fault_r      <= sfd_pkg::ST_OK;
    end else begin
      magic_r      <= magic_nxt;
      version_r    <= version_nxt;
      byte_index_r <= byte_index_nxt;
      crc_r        <= crc_nxt;
      fault_r      <= fault_nxt;
    end
  end

  // Each payload register is loaded only at its own frame offset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < sfd_pkg::PAYLOAD_DEPTH; i++) begin
      if (accept && idx == sfd_pkg::IDX_PAY_LO + 5'(i)) begin
        payload_r[i] <= in_tdata;
      end
    end
  end

endmodule

// ===== hw/rtl/sfd_queue.sv =====
// ----------------------------------------------------------------------------
// sfd_queue: frame record queue
// A small register FIFO between the front and back parts, so that the byte
// intake keeps running while the result side is stalled.
// ----------------------------------------------------------------------------
module sfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sfd_pkg::rec_port_t  push,
  input  logic                pop,
  output logic                full,
  output sfd_pkg::rec_port_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfd_pkg::frame_rec_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.rec   = entry_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.rec;
    end
  end

endmodule

// ===== hw/rtl/sfd_back.sv =====
// ----------------------------------------------------------------------------
// sfd_back: result delivery
// Takes frame records from the queue into the output register, clearing the
// payload fields of a failed frame, and holds each result until it is taken.
// ----------------------------------------------------------------------------
module sfd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfd_pkg::rec_port_t            head,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sfd_pkg::FIELD_W-1:0]   out_tdata,
  output logic [1:0]                    out_tuser
);

  logic                        valid_r, valid_nxt;
  logic [sfd_pkg::FIELD_W-1:0] data_r;
  logic [1:0]                  status_r;

  assign pop        = head.valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = status_r;

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // A frame that failed any check reports its status with all fields zero.
  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= head.rec.status;
      data_r   <= (head.rec.status == sfd_pkg::ST_OK) ? head.rec.fields : '0;
    end
  end

endmodule

// ===== hw/rtl/setpoint_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// setpoint_frame_decoder: 24-byte setpoint frame checker and field extractor
//
// Input stream: one received byte per transaction on in_tdata, with in_tuser
// set on the first byte of a frame (it also discards any partial frame).
// After 24 bytes the count wraps, so back-to-back frames need no start flag.
// Byte 0 is checked against frame_magic, byte 1 against protocol_version,
// and a CRC-16-CCITT over bytes 0..21 is compared with bytes 22..23.
// Output stream: one transaction per frame, the status on out_tuser and the
// payload fields on out_tdata (all zero when the status is not ok).
// Configuration: cfg_index 0 writes frame_magic, 1 writes protocol_version;
// other indexes are ignored. cfg_ready is always high.
// Throughput is one byte per cycle while the queue is not full, set by the
// byte-wide CRC update in the front part. The record enters the queue at
// the edge that accepts the last byte and moves into the output register
// once that register is empty or its result is being taken.
// When the receiver stalls, results collect in the queue; in_tready drops
// only while the queue is full. Reset clears the byte count, CRC, header
// status, queue and output valid, and sets both registers to zero.
// ----------------------------------------------------------------------------
module setpoint_frame_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_byte
  input  logic                         in_tuser,   // [0] frame_start
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [7:0] mode_byte, [15:8] sequence_res, [31:16] roll_setpoint,
  // [47:32] pitch_setpoint, [63:48] yaw_rate_setpoint, [79:64] climb_setpoint,
  // [95:80] thrust, [127:96] timestamp, [159:128] flag_bits
  output logic [sfd_pkg::FIELD_W-1:0]  out_tdata,
  output logic [1:0]                   out_tuser,  // [1:0] status
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [7:0]                   cfg_index,
  input  logic [7:0]                   cfg_data
);

  sfd_pkg::rec_port_t push;
  sfd_pkg::rec_port_t head;
  logic               queue_full;
  logic               pop;

  sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .push       (push)
  );

  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (queue_full),
    .head  (head)
  );

  sfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the setpoint frame decoder
// Sends 24-byte setpoint frames, some of them broken, cut short or mixed with
// stray bytes, under several magic and version settings. A frame checker
// tracks the byte count, header status and CRC-16-CCITT of the stream and
// compares every frame result, field by field, with its own prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int PHASE_BYTES  = 290;

  typedef enum int {FR_GOOD, FR_BAD_MAGIC, FR_BAD_VERSION, FR_BAD_BOTH, FR_BAD_CRC}
    frame_kind_t;

  // Frame checker: own copy of the decoder state, expected frame results.
  class frame_check;
    logic [7:0]          magic_reg;
    logic [7:0]          version_reg;
    logic [4:0]          byte_pos;
    logic [15:0]         crc_acc;
    logic [1:0]          fault;
    logic [7:0]          payload [sfd_pkg::PAYLOAD_DEPTH];
    sfd_pkg::frame_rec_t expected_frames [$];
    int                  err_count;

    function new();
      magic_reg   = 8'h00;
      version_reg = 8'h00;
      byte_pos    = 5'd0;
      crc_acc     = sfd_pkg::CRC_INIT;
      fault       = sfd_pkg::ST_OK;
      err_count   = 0;
    endfunction

    static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ sfd_pkg::CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] val);
      if (idx == sfd_pkg::REG_FRAME_MAGIC) begin
        magic_reg = val;
      end else if (idx == sfd_pkg::REG_PROTOCOL_VERSION) begin
        version_reg = val;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      logic [4:0]          idx;
      logic [15:0]         rx_crc;
      sfd_pkg::frame_rec_t rec;
      if (start) begin
        byte_pos = sfd_pkg::IDX_FIRST;
      end
      idx = byte_pos;
      if (idx == sfd_pkg::IDX_FIRST) begin
        crc_acc = crc16_step(sfd_pkg::CRC_INIT, b);
        fault   = (b != magic_reg) ? sfd_pkg::ST_BAD_MAGIC : sfd_pkg::ST_OK;
      end else if (idx <= sfd_pkg::IDX_CRC_END) begin
        crc_acc = crc16_step(crc_acc, b);
        if (idx == sfd_pkg::IDX_VERSION && fault == sfd_pkg::ST_OK && b != version_reg) begin
          fault = sfd_pkg::ST_BAD_VERSION;
        end
      end
      if (idx >= sfd_pkg::IDX_PAY_LO && idx <= sfd_pkg::IDX_PAY_HI) begin
        payload[idx - sfd_pkg::IDX_PAY_LO] = b;
      end
      if (idx != sfd_pkg::IDX_LAST) begin
        byte_pos = idx + 5'd1;
        return;
      end
      byte_pos = sfd_pkg::IDX_FIRST;
      rx_crc = {b, payload[sfd_pkg::IDX_PAY_HI - sfd_pkg::IDX_PAY_LO]};
      if (fault != sfd_pkg::ST_OK) begin
        rec.status = fault;
      end else if (rx_crc != crc_acc) begin
        rec.status = sfd_pkg::ST_BAD_CRC;
      end else begin
        rec.status = sfd_pkg::ST_OK;
      end
      rec.fields = '0;
      if (rec.status == sfd_pkg::ST_OK) begin
        for (int i = 0; i < sfd_pkg::FIELD_BYTES; i++) begin
          rec.fields[i*8 +: 8] = payload[i];
        end
      end
      expected_frames.push_back(rec);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_count++;
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0h expected %0h", name, got, want));
      end
    endtask

    task check_frame(logic [1:0] st, logic [sfd_pkg::FIELD_W-1:0] data);
      sfd_pkg::frame_rec_t want;
      if (expected_frames.size() == 0) begin
        report("frame result with no frame pending");
        return;
      end
      want = expected_frames.pop_front();
      cmp_field("status", 32'(st), 32'(want.status));
      cmp_field("mode_byte", 32'(data[7:0]), 32'(want.fields[7:0]));
      cmp_field("sequence_res", 32'(data[15:8]), 32'(want.fields[15:8]));
      cmp_field("roll_setpoint", 32'(data[31:16]), 32'(want.fields[31:16]));
      cmp_field("pitch_setpoint", 32'(data[47:32]), 32'(want.fields[47:32]));
      cmp_field("yaw_rate_setpoint", 32'(data[63:48]), 32'(want.fields[63:48]));
      cmp_field("climb_setpoint", 32'(data[79:64]), 32'(want.fields[79:64]));
      cmp_field("thrust", 32'(data[95:80]), 32'(want.fields[95:80]));
      cmp_field("timestamp", data[127:96], want.fields[127:96]);
      cmp_field("flag_bits", data[159:128], want.fields[159:128]);
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [7:0]                  in_tdata = 8'h00;
  logic                        in_tuser = 1'b0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [sfd_pkg::FIELD_W-1:0] out_tdata;
  logic [1:0]                  out_tuser;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [7:0]                  cfg_index = 8'h00;
  logic [7:0]                  cfg_data = 8'h00;

  frame_check sb = new();
  int         idle_pct = 8;
  int         bytes_sent = 0;
  int         cycle_count = 0;

  setpoint_frame_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Transaction monitors.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (in_tvalid && in_tready) begin
        sb.note_byte(in_tdata, in_tuser);
      end
      if (out_tvalid && out_tready) begin
        sb.check_frame(out_tuser, out_tdata);
      end
    end
  end

  // Called and returns at a falling edge; in_tvalid stays high on return.
  task automatic send_byte(logic [7:0] b, logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Builds a frame against the current register values and sends its first
  // n_bytes bytes. A fixed fill puts even_b on even and odd_b on odd offsets,
  // which lands on the low and high bytes of the 16-bit fields.
  task automatic send_frame(frame_kind_t kind, int n_bytes, logic first_start,
                            logic fixed_fill, logic [7:0] even_b, logic [7:0] odd_b);
    logic [7:0]  f [sfd_pkg::FRAME_LEN];
    logic [15:0] crc;
    f[0] = sb.magic_reg;
    f[1] = sb.version_reg;
    if (kind == FR_BAD_MAGIC || kind == FR_BAD_BOTH) begin
      f[0] = f[0] ^ 8'($urandom_range(1, 255));
    end
    if (kind == FR_BAD_VERSION || kind == FR_BAD_BOTH) begin
      f[1] = f[1] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 2; i <= 21; i++) begin
      f[i] = fixed_fill ? ((i % 2 == 0) ? even_b : odd_b) : 8'($urandom);
    end
    crc = sfd_pkg::CRC_INIT;
    for (int i = 0; i <= 21; i++) begin
      crc = frame_check::crc16_step(crc, f[i]);
    end
    if (kind == FR_BAD_CRC) begin
      crc = crc ^ 16'($urandom_range(1, 65535));
    end
    f[22] = crc[7:0];
    f[23] = crc[15:8];
    for (int i = 0; i < n_bytes; i++) begin
      send_byte(f[i], (i == 0) ? first_start : 1'b0);
    end
  endtask

  // Mostly whole frames with random content; some cut short, some stray bytes.
  task automatic random_traffic(int n_target);
    int          first_byte;
    int          r;
    logic        need_start;
    frame_kind_t kind;
    first_byte = bytes_sent;
    need_start = 1'b1;
    while (bytes_sent - first_byte < n_target) begin
      r = $urandom_range(99);
      if (r < 90) begin
        if (r < 60) begin
          kind = FR_GOOD;
        end else if (r < 68) begin
          kind = FR_BAD_MAGIC;
        end else if (r < 76) begin
          kind = FR_BAD_VERSION;
        end else if (r < 80) begin
          kind = FR_BAD_BOTH;
        end else begin
          kind = FR_BAD_CRC;
        end
        send_frame(kind, sfd_pkg::FRAME_LEN, need_start || ($urandom_range(1) == 1),
                   1'b0, 8'h00, 8'h00);
        need_start = 1'b0;
      end else if (r < 95) begin
        send_frame(FR_GOOD, $urandom_range(1, sfd_pkg::FRAME_LEN - 1),
                   need_start || ($urandom_range(1) == 1), 1'b0, 8'h00, 8'h00);
        need_start = 1'b1;
      end else begin
        repeat ($urandom_range(1, 30)) begin
          send_byte(8'($urandom), $urandom_range(9) == 0);
        end
        need_start = 1'b1;
      end
    end
  endtask

  // Lets every pending frame result drain before a register write or the end.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers still at their reset values; the first byte carries no start.
    send_frame(FR_GOOD, sfd_pkg::FRAME_LEN, 1'b0, 1'b0, 8'h00, 8'h00);
    drain();
    write_reg(sfd_pkg::REG_FRAME_MAGIC, 8'hA5);
    write_reg(sfd_pkg::REG_PROTOCOL_VERSION, 8'h02);
    write_reg(8'd2, 8'h5A);
    write_reg(8'hFF, 8'hC3);

    // Field extremes: most negative and most positive setpoints, all zeros
    // and all ones; the second and fourth frames follow without a start flag.
    send_frame(FR_GOOD, sfd_pkg::FRAME_LEN, 1'b1, 1'b1, 8'h00, 8'h80);
    send_frame(FR_GOOD, sfd_pkg::FRAME_LEN, 1'b0, 1'b1, 8'hFF, 8'h7F);
    send_frame(FR_GOOD, sfd_pkg::FRAME_LEN, 1'b1, 1'b1, 8'h00, 8'h00);
    send_frame(FR_GOOD, sfd_pkg::FRAME_LEN, 1'b0, 1'b1, 8'hFF, 8'hFF);
    send_frame(FR_BAD_MAGIC, sfd_pkg::FRAME_LEN, 1'b1, 1'b0, 8'h00, 8'h00);
    send_frame(FR_BAD_VERSION, sfd_pkg::FRAME_LEN, 1'b1, 1'b0, 8'h00, 8'h00);
    send_frame(FR_BAD_BOTH, sfd_pkg::FRAME_LEN, 1'b1, 1'b0, 8'h00, 8'h00);
    send_frame(FR_BAD_CRC, sfd_pkg::FRAME_LEN, 1'b1, 1'b0, 8'h00, 8'h00);
    // A start flag in the middle of a frame drops the partial frame.
    send_frame(FR_GOOD, 10, 1'b1, 1'b0, 8'h00, 8'h00);
    send_frame(FR_GOOD, sfd_pkg::FRAME_LEN, 1'b1, 1'b0, 8'h00, 8'h00);

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(sfd_pkg::REG_FRAME_MAGIC, 8'h00);
          write_reg(sfd_pkg::REG_PROTOCOL_VERSION, 8'hFF);
        end
        1: begin
          write_reg(sfd_pkg::REG_FRAME_MAGIC, 8'hFF);
          write_reg(sfd_pkg::REG_PROTOCOL_VERSION, 8'h00);
        end
        default: begin
          write_reg(sfd_pkg::REG_FRAME_MAGIC, 8'($urandom));
          write_reg(sfd_pkg::REG_PROTOCOL_VERSION, 8'($urandom));
        end
      endcase
      write_reg(8'($urandom_range(2, 255)), 8'($urandom));
      // One phase runs with no idling on either side.
      idle_pct = (p == 1) ? 0 : 8;
      random_traffic(PHASE_BYTES);
    end

    drain();
    if (sb.err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== setpoint_frame_decoder.f =====
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_front.sv
hw/rtl/sfd_queue.sv
hw/rtl/sfd_back.sv
hw/rtl/setpoint_frame_decoder.sv
verif/testbench.sv
